@@ src/glsp_pkg.sv @@
// glsp_pkg: constants, codes, types and result struct for the glyph layout shelf packer
// no dependencies

package glsp_pkg;

    localparam int ATLAS_SIZE = 512;
    localparam int MAX_PAGES  = 255;
    localparam int TAB_UNITS  = 4;

    localparam int PEN_W      = 16;
    localparam int DIM_W      = 10;
    localparam int PAGE_W     = 8;
    localparam int FONT_W     = 8;
    localparam int WRAP_W     = 16;
    localparam int ACT_W      = 2;
    localparam int SUM_W      = DIM_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = PEN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0]  ATLAS_LIM = SUM_W'(ATLAS_SIZE);
    localparam logic [PAGE_W-1:0] PAGE_MAX  = PAGE_W'(MAX_PAGES);

    localparam logic [FONT_W-1:0] FONT_RESET = FONT_W'(16);
    localparam logic [WRAP_W-1:0] WRAP_RESET = '1;

    typedef logic [ACT_W-1:0] action_t;
    localparam action_t ACT_GLYPH   = action_t'(0);
    localparam action_t ACT_TAB     = action_t'(1);
    localparam action_t ACT_NEWLINE = action_t'(2);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FONT_HEIGHT = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_WRAP_LIMIT  = cfg_idx_t'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAB_START,
        ST_TAB_WAIT,
        ST_NEWLINE,
        ST_GLYPH_SHELF,
        ST_GLYPH_PLACE,
        ST_DONE
    } lay_state_t;

    typedef struct packed {
        logic              accepted;
        logic              glyph_placed;
        logic [PEN_W-1:0]  screen_x;
        logic [PEN_W-1:0]  screen_y;
        logic [PAGE_W-1:0] page_index;
        logic [DIM_W-1:0]  atlas_x;
        logic [DIM_W-1:0]  atlas_y;
        logic [PEN_W-1:0]  glyph_number;
        logic [PEN_W-1:0]  widest_line;
    } glsp_result_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

@@ src/glsp_in_if.sv @@
// glsp_in_if: input channel carrying one text item per transaction
// depends on glsp_pkg

interface glsp_in_if;
    import glsp_pkg::*;

    logic             valid;
    logic             ready;
    action_t          action;
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;

    modport source (output valid, action, glyph_width, glyph_height, input ready);
    modport sink   (input valid, action, glyph_width, glyph_height, output ready);
endinterface

@@ src/glsp_out_if.sv @@
// glsp_out_if: result channel carrying one layout result per transaction
// depends on glsp_pkg

interface glsp_out_if;
    import glsp_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic              glyph_placed;
    logic [PEN_W-1:0]  screen_x;
    logic [PEN_W-1:0]  screen_y;
    logic [PAGE_W-1:0] page_index;
    logic [DIM_W-1:0]  atlas_x;
    logic [DIM_W-1:0]  atlas_y;
    logic [PEN_W-1:0]  glyph_number;
    logic [PEN_W-1:0]  widest_line;

    modport source (output valid, accepted, glyph_placed, screen_x, screen_y, page_index,
                    atlas_x, atlas_y, glyph_number, widest_line, input ready);
    modport sink   (input valid, accepted, glyph_placed, screen_x, screen_y, page_index,
                    atlas_x, atlas_y, glyph_number, widest_line, output ready);
endinterface

@@ src/glyph_layout_shelf_packer_top.sv @@
// glyph_layout_shelf_packer_top: pen layout and shelf packing over square atlas pages
// depends on glsp_pkg, glsp_in_if, glsp_out_if, glsp_div
// a tab runs through the bit-serial remainder unit unless the font height is zero; a glyph takes
// the shelf and place steps (only the shelf step when rejected); a waiting output result stalls done
// throughput: one transaction at a time; the next item is taken once the result is registered
// the result register lets a new item start while the previous result waits
// reset: async active low, clears pen, counters and packer, font height 16, wrap disabled

module glyph_layout_shelf_packer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    glsp_in_if.sink                         in_ch,
    glsp_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [glsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import glsp_pkg::*;

    lay_state_t        state_reg, state_next;
    logic [FONT_W-1:0] font_reg;
    logic [WRAP_W-1:0] wrap_reg;
    logic [PEN_W-1:0]  pen_x_reg, pen_y_reg, number_reg, widest_reg;
    logic [DIM_W-1:0]  line_tall_reg;
    logic [PAGE_W-1:0] pages_reg;
    logic [DIM_W-1:0]  shelf_x_reg, shelf_y_reg, shelf_tall_reg;
    logic [DIM_W-1:0]  w_reg, h_reg;
    glsp_result_t      res_reg, out_reg;
    glsp_result_t      res_first, res_done;
    logic              out_valid_reg;

    logic              in_take, out_take, res_load;
    div_ctl_t          div_cmd, div_stat;
    logic [DIM_W-1:0]  tab_w, div_rem;

    // shelf step
    logic              first_page, reject, new_shelf;
    logic [DIM_W-1:0]  sx0, sy0, st0;
    logic [SUM_W-1:0]  w_ext, h_ext;

    // place step
    logic              page_full, wrap_hit;
    logic [PAGE_W-1:0] pg1;
    logic [DIM_W-1:0]  px, py, pt, tall;
    logic [PEN_W-1:0]  pen_sx;

    assign tab_w    = DIM_W'(font_reg) * DIM_W'(TAB_UNITS);
    assign in_take  = in_ch.valid && in_ch.ready;
    assign out_take = out_valid_reg && out_ch.ready;

    always_comb
    begin
        w_ext      = {1'b0, w_reg};
        h_ext      = {1'b0, h_reg};
        first_page = (pages_reg == '0);
        sx0        = first_page ? '0 : shelf_x_reg;
        sy0        = first_page ? '0 : shelf_y_reg;
        st0        = first_page ? '0 : shelf_tall_reg;
        reject     = (w_ext >= ATLAS_LIM) || (h_ext >= ATLAS_LIM) ||
                     (w_reg == '0) || (h_reg == '0);
        new_shelf  = ({1'b0, sx0} + w_ext) >= ATLAS_LIM;

        page_full  = ({1'b0, shelf_y_reg} + h_ext) >= ATLAS_LIM;
        pg1        = (page_full && (pages_reg < PAGE_MAX)) ? pages_reg + 1'b1 : pages_reg;
        px         = page_full ? '0 : shelf_x_reg;
        py         = page_full ? '0 : shelf_y_reg;
        pt         = page_full ? '0 : shelf_tall_reg;
        pen_sx     = pen_x_reg + PEN_W'(w_reg);
        tall       = (line_tall_reg > h_reg) ? line_tall_reg : h_reg;
        wrap_hit   = !wrap_reg[WRAP_W-1] && (pen_sx >= wrap_reg);

        res_first          = '0;
        res_first.accepted = (in_ch.action == ACT_TAB) || (in_ch.action == ACT_NEWLINE);
        res_done             = res_reg;
        res_done.widest_line = widest_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    priority if (in_ch.action == ACT_TAB)
                        state_next = ST_TAB_START;
                    else if (in_ch.action == ACT_NEWLINE)
                        state_next = ST_NEWLINE;
                    else
                        state_next = ST_GLYPH_SHELF;
                end
            end
            ST_TAB_START:   state_next = (tab_w == '0) ? ST_DONE : ST_TAB_WAIT;
            ST_TAB_WAIT:    state_next = div_stat.done ? ST_DONE : ST_TAB_WAIT;
            ST_NEWLINE:     state_next = ST_DONE;
            ST_GLYPH_SHELF: state_next = reject ? ST_DONE : ST_GLYPH_PLACE;
            ST_GLYPH_PLACE: state_next = ST_DONE;
            ST_DONE:        state_next = (!out_valid_reg || out_ch.ready) ? ST_IDLE : ST_DONE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ch.ready   = (state_reg == ST_IDLE);
        div_cmd.start = (state_reg == ST_TAB_START) && (tab_w != '0);
        div_cmd.done  = 1'b0;
        res_load      = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);
    end

    glsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (div_cmd),
        .ctl_out   (div_stat),
        .dividend  (pen_x_reg),
        .divisor   (tab_w),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            font_reg       <= FONT_RESET;
            wrap_reg       <= WRAP_RESET;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            line_tall_reg  <= '0;
            number_reg     <= '0;
            widest_reg     <= '0;
            pages_reg      <= '0;
            shelf_x_reg    <= '0;
            shelf_y_reg    <= '0;
            shelf_tall_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FONT_HEIGHT: font_reg <= cfg_data[FONT_W-1:0];
                    CFG_WRAP_LIMIT:  wrap_reg <= cfg_data[WRAP_W-1:0];
                    default:         ;
                endcase
            end
            unique case (state_reg)
                ST_TAB_WAIT:
                begin
                    if (div_stat.done)
                        pen_x_reg <= pen_x_reg + PEN_W'(tab_w) - PEN_W'(div_rem);
                end
                ST_NEWLINE:
                begin
                    pen_y_reg     <= pen_y_reg + PEN_W'(line_tall_reg);
                    pen_x_reg     <= '0;
                    line_tall_reg <= DIM_W'(font_reg);
                end
                ST_GLYPH_SHELF:
                begin
                    if (first_page)
                        pages_reg <= PAGE_W'(1);
                    if (!reject && new_shelf)
                    begin
                        shelf_x_reg    <= '0;
                        shelf_y_reg    <= DIM_W'(sy0 + st0);
                        shelf_tall_reg <= '0;
                    end
                    else
                    begin
                        shelf_x_reg    <= sx0;
                        shelf_y_reg    <= sy0;
                        shelf_tall_reg <= st0;
                    end
                end
                ST_GLYPH_PLACE:
                begin
                    pages_reg      <= pg1;
                    number_reg     <= number_reg + 1'b1;
                    shelf_tall_reg <= (h_reg > pt) ? h_reg : pt;
                    shelf_x_reg    <= DIM_W'(px + w_reg);
                    shelf_y_reg    <= py;
                    if (wrap_hit)
                    begin
                        pen_x_reg     <= '0;
                        pen_y_reg     <= pen_y_reg + PEN_W'(tall);
                        line_tall_reg <= DIM_W'(font_reg);
                    end
                    else
                    begin
                        pen_x_reg     <= pen_sx;
                        line_tall_reg <= tall;
                        if (pen_sx > widest_reg)
                            widest_reg <= pen_sx;
                    end
                end
                default: ;
            endcase
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    w_reg   <= in_ch.glyph_width;
                    h_reg   <= in_ch.glyph_height;
                    res_reg <= res_first;
                end
            end
            ST_GLYPH_PLACE:
            begin
                res_reg.accepted     <= 1'b1;
                res_reg.glyph_placed <= 1'b1;
                res_reg.screen_x     <= pen_x_reg;
                res_reg.screen_y     <= pen_y_reg;
                res_reg.page_index   <= pg1 - 1'b1;
                res_reg.atlas_x      <= px;
                res_reg.atlas_y      <= py;
                res_reg.glyph_number <= number_reg;
            end
            default: ;
        endcase
        if (res_load)
            out_reg <= res_done;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.accepted     = out_reg.accepted;
    assign out_ch.glyph_placed = out_reg.glyph_placed;
    assign out_ch.screen_x     = out_reg.screen_x;
    assign out_ch.screen_y     = out_reg.screen_y;
    assign out_ch.page_index   = out_reg.page_index;
    assign out_ch.atlas_x      = out_reg.atlas_x;
    assign out_ch.atlas_y      = out_reg.atlas_y;
    assign out_ch.glyph_number = out_reg.glyph_number;
    assign out_ch.widest_line  = out_reg.widest_line;

endmodule

@@ src/glsp_div.sv @@
// glsp_div: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on glsp_pkg

module glsp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  glsp_pkg::div_ctl_t         ctl_in,
    output glsp_pkg::div_ctl_t         ctl_out,
    input  logic [glsp_pkg::PEN_W-1:0] dividend,
    input  logic [glsp_pkg::DIM_W-1:0] divisor,
    output logic [glsp_pkg::DIM_W-1:0] remainder
);
    import glsp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PEN_W-1:0]     dvd_reg, dvd_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [DIM_W-1:0]     dsr_reg, dsr_next;
    logic [SUM_W-1:0]     trial;
    logic [SUM_W-1:0]     diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[PEN_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (ctl_in.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[PEN_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;
    assign remainder     = rem_reg;

endmodule

@@ sim/glsp_layout_checker.sv @@
// glsp_layout_checker: watches the text item and result channels and the register port,
// keeps its own pen and shelf packer state and compares every result field by field
// depends on glsp_pkg, glsp_in_if, glsp_out_if

module glsp_layout_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    glsp_in_if                              in_ch,
    glsp_out_if                             out_ch,
    input  logic                            cfg_we,
    input  glsp_pkg::cfg_idx_t              cfg_index,
    input  logic [glsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              item_count,
    output int                              placed_count,
    output int                              rejected_count,
    output int                              top_page
);
    import glsp_pkg::*;

    logic [FONT_W-1:0] font_h;
    logic [WRAP_W-1:0] wrap_at;

    logic [PEN_W-1:0]  pen_x;
    logic [PEN_W-1:0]  pen_y;
    logic [DIM_W-1:0]  line_tall;
    logic [PEN_W-1:0]  glyph_count;
    logic [PEN_W-1:0]  widest;
    logic [PAGE_W-1:0] pages_open;
    logic [DIM_W-1:0]  shelf_x;
    logic [DIM_W-1:0]  shelf_y;
    logic [DIM_W-1:0]  shelf_tall;

    glsp_result_t layout_results_due[$];
    int           fails;
    int           items;
    int           placed;
    int           rejected;
    int           highest_page;

    function automatic void start_page();
        if (pages_open < PAGE_MAX)
            pages_open = pages_open + 1'b1;
        shelf_x    = '0;
        shelf_y    = '0;
        shelf_tall = '0;
    endfunction

    function automatic glsp_result_t advance_layout(action_t act, logic [DIM_W-1:0] w,
                                                    logic [DIM_W-1:0] h);
        glsp_result_t     r;
        logic [DIM_W-1:0] tab_step;
        logic [PEN_W-1:0] nx;
        logic [PEN_W-1:0] ny;
        logic [DIM_W-1:0] tall;
        r = '0;
        r.accepted = 1'b1;
        if (act == ACT_TAB)
        begin
            tab_step = DIM_W'(TAB_UNITS * font_h);
            if (tab_step != '0)
                pen_x = pen_x + PEN_W'(tab_step) - (pen_x % PEN_W'(tab_step));
        end
        else if (act == ACT_NEWLINE)
        begin
            pen_y     = pen_y + PEN_W'(line_tall);
            pen_x     = '0;
            line_tall = DIM_W'(font_h);
        end
        else
        begin
            // any other action code is a glyph; the first one opens a page even if rejected
            if (pages_open == '0)
                start_page();
            if (w >= ATLAS_LIM || h >= ATLAS_LIM || w == '0 || h == '0)
            begin
                r.accepted = 1'b0;
            end
            else
            begin
                if ({1'b0, shelf_x} + w >= ATLAS_LIM)
                begin
                    shelf_y    = shelf_y + shelf_tall;
                    shelf_x    = '0;
                    shelf_tall = '0;
                end
                if ({1'b0, shelf_y} + h >= ATLAS_LIM)
                    start_page();
                r.glyph_placed = 1'b1;
                r.screen_x     = pen_x;
                r.screen_y     = pen_y;
                r.page_index   = pages_open - 1'b1;
                r.atlas_x      = shelf_x;
                r.atlas_y      = shelf_y;
                r.glyph_number = glyph_count;
                glyph_count    = glyph_count + 1'b1;
                if (h > shelf_tall)
                    shelf_tall = h;
                shelf_x = shelf_x + w;
                nx      = pen_x + PEN_W'(w);
                ny      = pen_y;
                tall    = (line_tall > h) ? line_tall : h;
                if (!wrap_at[WRAP_W-1] && nx >= wrap_at)
                begin
                    ny   = ny + PEN_W'(tall);
                    nx   = '0;
                    tall = DIM_W'(font_h);
                end
                pen_x     = nx;
                pen_y     = ny;
                line_tall = tall;
                if (nx > widest)
                    widest = nx;
            end
        end
        r.widest_line = widest;
        return r;
    endfunction

    task automatic check_field(string field, logic [PEN_W-1:0] want, logic [PEN_W-1:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        glsp_result_t due;
        if (!rst_n)
        begin
            font_h       = FONT_RESET;
            wrap_at      = WRAP_RESET;
            pen_x        = '0;
            pen_y        = '0;
            line_tall    = '0;
            glyph_count  = '0;
            widest       = '0;
            pages_open   = '0;
            shelf_x      = '0;
            shelf_y      = '0;
            shelf_tall   = '0;
            layout_results_due.delete();
            fails        = 0;
            items        = 0;
            placed       = 0;
            rejected     = 0;
            highest_page = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FONT_HEIGHT: font_h  = cfg_data[FONT_W-1:0];
                    CFG_WRAP_LIMIT:  wrap_at = cfg_data[WRAP_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (layout_results_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result transaction with none outstanding, actual accepted=%0b",
                             $time, out_ch.accepted);
                end
                else
                begin
                    due = layout_results_due.pop_front();
                    check_field("accepted", PEN_W'(due.accepted), PEN_W'(out_ch.accepted));
                    check_field("glyph_placed", PEN_W'(due.glyph_placed),
                                PEN_W'(out_ch.glyph_placed));
                    check_field("screen_x", due.screen_x, out_ch.screen_x);
                    check_field("screen_y", due.screen_y, out_ch.screen_y);
                    check_field("page_index", PEN_W'(due.page_index), PEN_W'(out_ch.page_index));
                    check_field("atlas_x", PEN_W'(due.atlas_x), PEN_W'(out_ch.atlas_x));
                    check_field("atlas_y", PEN_W'(due.atlas_y), PEN_W'(out_ch.atlas_y));
                    check_field("glyph_number", due.glyph_number, out_ch.glyph_number);
                    check_field("widest_line", due.widest_line, out_ch.widest_line);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                due = advance_layout(in_ch.action, in_ch.glyph_width, in_ch.glyph_height);
                layout_results_due.push_back(due);
                items++;
                if (due.glyph_placed)
                begin
                    placed++;
                    if (int'(due.page_index) > highest_page)
                        highest_page = int'(due.page_index);
                end
                if (!due.accepted)
                    rejected++;
            end
        end
        fail_count     <= fails;
        pending        <= layout_results_due.size();
        item_count     <= items;
        placed_count   <= placed;
        rejected_count <= rejected;
        top_page       <= highest_page;
    end

endmodule

@@ sim/tb_glyph_layout_shelf_packer_top.sv @@
// tb_glyph_layout_shelf_packer_top: drives text items and register settings into the layout
// block with random idling on both sides; checking is done by glsp_layout_checker
// depends on glsp_pkg, glsp_in_if, glsp_out_if, glyph_layout_shelf_packer_top, glsp_layout_checker

module tb_glyph_layout_shelf_packer_top;
    import glsp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {MIX_TEXT, MIX_BIG, MIX_WIDE} text_mix_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int item_count;
    int placed_count;
    int rejected_count;
    int top_page;
    int cycles   = 0;
    int settings = 1;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit rx_hold  = 1'b0;

    glsp_in_if  in_ch ();
    glsp_out_if out_ch ();

    glyph_layout_shelf_packer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glsp_layout_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .item_count     (item_count),
        .placed_count   (placed_count),
        .rejected_count (rejected_count),
        .top_page       (top_page)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** glyph_layout_shelf_packer_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_layout(logic [FONT_W-1:0] font, logic [WRAP_W-1:0] wrap);
        write_reg(CFG_FONT_HEIGHT, CFG_DATA_W'(font));
        write_reg(CFG_WRAP_LIMIT, CFG_DATA_W'(wrap));
        settings++;
    endtask

    task automatic send_item(action_t act, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.glyph_width  <= w;
        in_ch.glyph_height <= h;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(text_mix_t mix);
        int               r;
        int               noise_cut;
        int               tab_cut;
        int               line_cut;
        action_t          act;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        noise_cut = (mix == MIX_BIG) ? 4 : 10;
        tab_cut   = (mix == MIX_BIG) ? 8 : 20;
        line_cut  = (mix == MIX_BIG) ? 12 : (mix == MIX_WIDE) ? tab_cut : 30;
        r = $urandom_range(0, 99);
        w = DIM_W'($urandom);
        h = DIM_W'($urandom);
        if (r < noise_cut)
            act = action_t'($urandom_range(0, 3));
        else if (r < tab_cut)
            act = ACT_TAB;
        else if (r < line_cut)
            act = ACT_NEWLINE;
        else
        begin
            act = ACT_GLYPH;
            case (mix)
                MIX_BIG:
                begin
                    w = DIM_W'($urandom_range(300, 511));
                    h = DIM_W'($urandom_range(257, 511));
                end
                MIX_WIDE:
                begin
                    w = DIM_W'($urandom_range(400, 511));
                    h = DIM_W'($urandom_range(1, 40));
                end
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        w = DIM_W'($urandom_range(1, 511));
                        h = DIM_W'($urandom_range(1, 511));
                    end
                    else
                    begin
                        w = DIM_W'($urandom_range(1, 40));
                        h = DIM_W'($urandom_range(1, 48));
                    end
                end
            endcase
        end
        send_item(act, w, h);
    endtask

    task automatic run_phase(logic [FONT_W-1:0] font, logic [WRAP_W-1:0] wrap,
                             text_mix_t mix, int count);
        set_layout(font, wrap);
        repeat (count) send_random(mix);
        drain();
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_FONT_HEIGHT;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_GLYPH;
        in_ch.glyph_width  = '0;
        in_ch.glyph_height = '0;
        out_ch.ready       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty glyph first: page still opens
        send_item(ACT_GLYPH, 10'd0, 10'd5);
        send_item(ACT_GLYPH, 10'd5, 10'd0);
        send_item(ACT_GLYPH, 10'd512, 10'd10);
        send_item(ACT_GLYPH, 10'd10, 10'd512);
        send_item(ACT_GLYPH, 10'd1023, 10'd1023);
        send_item(ACT_GLYPH, 10'd1, 10'd1);
        // new shelf then new page
        send_item(ACT_GLYPH, 10'd511, 10'd511);
        send_item(ACT_GLYPH, 10'd511, 10'd1);
        send_item(ACT_TAB, 10'd0, 10'd0);
        send_item(ACT_NEWLINE, 10'd1023, 10'd1023);
        send_item(action_t'(3), 10'd20, 10'd30);
        send_item(ACT_TAB, 10'd1023, 10'd0);
        send_item(ACT_GLYPH, 10'd100, 10'd40);
        send_item(ACT_NEWLINE, 10'd0, 10'd0);
        send_item(ACT_NEWLINE, 10'd0, 10'd0);
        send_item(action_t'(3), 10'd0, 10'd0);
        send_item(ACT_GLYPH, 10'd1023, 10'd1);
        drain();

        run_phase(8'd16, 16'd200, MIX_TEXT, 120);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_phase(8'd255, 16'h7FFF, MIX_TEXT, 80);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_phase(8'd0, 16'h8000, MIX_TEXT, 70);
        run_phase(8'd1, 16'd0, MIX_TEXT, 70);
        run_phase(8'd8, 16'd1000, MIX_BIG, 300);

        // receiver holds off while the sender streams
        set_layout(8'd37, 16'd63);
        rx_hold  = 1'b1;
        tx_quiet = 1'b1;
        repeat (24) send_random(MIX_TEXT);
        tx_quiet = 1'b0;
        drain();

        run_phase(8'd200, 16'hFFFF, MIX_WIDE, 170);

        $display("covered %0d items under %0d register settings: %0d glyphs placed, %0d rejected",
                 item_count, settings, placed_count, rejected_count);
        $display("highest atlas page %0d, receiver hold of %0d cycles under a streaming sender",
                 top_page, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("** glyph_layout_shelf_packer_top: PASSED **");
        else
            $display("** glyph_layout_shelf_packer_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/glsp_pkg.sv
src/glsp_in_if.sv
src/glsp_out_if.sv
src/glsp_div.sv
src/glyph_layout_shelf_packer_top.sv
sim/glsp_layout_checker.sv
sim/tb_glyph_layout_shelf_packer_top.sv
